[hw/rtl/esc_pkg.sv]
// Shared types, constants and helpers for the epoch seconds to calendar core.
// Used by esc_ctrl, esc_datapath and epoch_seconds_to_calendar_core.
`default_nettype none

package esc_pkg;

    // Datapath operation codes issued by the controller
    typedef logic [3:0] op_t;

    localparam op_t OP_NONE    = 4'd0;
    localparam op_t OP_LOAD    = 4'd1;
    localparam op_t OP_MUL60S  = 4'd2;
    localparam op_t OP_SPL60S  = 4'd3;
    localparam op_t OP_MUL60M  = 4'd4;
    localparam op_t OP_SPL60M  = 4'd5;
    localparam op_t OP_MUL24   = 4'd6;
    localparam op_t OP_SPL24   = 4'd7;
    localparam op_t OP_MUL7    = 4'd8;
    localparam op_t OP_SPL7    = 4'd9;
    localparam op_t OP_YEAR    = 4'd10;
    localparam op_t OP_MONTH   = 4'd11;
    localparam op_t OP_PUBLISH = 4'd12;

    // Command from controller to datapath
    typedef struct packed {
        op_t op;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic year_stop;
        logic month_stop;
    } status_t;

    // Epoch start and its residues for the century rules
    localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
    localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
    localparam logic [8:0]  EPOCH_MOD400  = 9'd370;

    // Reciprocals for exact constant division; the 60 and 24 ones hold for any 32-bit value
    localparam logic [31:0] RECIP_60 = 32'h8888_8889;  // >> 37
    localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;  // >> 36
    localparam logic [31:0] RECIP_7  = 32'd599187;     // >> 22, exact below 2^16+

    localparam logic [8:0] DAYS_LEAP   = 9'd366;
    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [3:0] LAST_MONTH  = 4'd11;

    // Month length, month counted from 0 = January
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/esc_datapath.sv]
// Datapath: reciprocal divider, year and month walk, result registers.
// Depends on esc_pkg; driven by esc_ctrl commands.
`default_nettype none

module esc_datapath (
    input  wire logic            clk,
    input  wire esc_pkg::cmd_t   cmd,
    input  wire logic [31:0]     epoch_seconds,
    output esc_pkg::status_t     status,
    output logic [5:0]           second_of_minute,
    output logic [5:0]           minute_of_hour,
    output logic [4:0]           hour_of_day,
    output logic [2:0]           day_of_week,
    output logic [11:0]          calendar_year,
    output logic [3:0]           month_number,
    output logic [4:0]           day_of_month
);

    // Working registers
    logic [31:0] work_reg, work_next;
    logic [63:0] prod_reg, prod_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hour_reg, hour_next;
    logic [2:0]  wday_reg, wday_next;
    logic [15:0] rem_reg, rem_next;
    logic [11:0] year_reg, year_next;
    logic [6:0]  ymod100_reg, ymod100_next;
    logic [8:0]  ymod400_reg, ymod400_next;
    logic [3:0]  month_reg, month_next;

    // Result registers
    logic [5:0]  out_sec_reg;
    logic [5:0]  out_min_reg;
    logic [4:0]  out_hour_reg;
    logic [2:0]  out_wday_reg;
    logic [11:0] out_year_reg;
    logic [3:0]  out_month_reg;
    logic [4:0]  out_day_reg;

    logic [31:0] mult_b;
    logic [26:0] q60;
    logic [15:0] q24;
    logic [15:0] q7;
    logic [31:0] r60;
    logic [31:0] r24;
    logic [31:0] r7;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    // Shared multiplier operand
    always_comb
    begin
        case (cmd.op)
            esc_pkg::OP_MUL24: mult_b = esc_pkg::RECIP_24;
            esc_pkg::OP_MUL7:  mult_b = esc_pkg::RECIP_7;
            default:           mult_b = esc_pkg::RECIP_60;
        endcase
    end

    assign prod_next = {32'd0, work_reg} * {32'd0, mult_b};

    // Quotients and remainders from the registered product
    assign q60 = prod_reg[63:37];
    assign q24 = prod_reg[51:36];
    assign q7  = prod_reg[37:22];
    assign r60 = work_reg - ({5'd0, q60} * 32'd60);
    assign r24 = work_reg - ({16'd0, q24} * 32'd24);
    assign r7  = work_reg - ({16'd0, q7} * 32'd7);

    // Gregorian leap rule from tracked residues
    assign leap = (year_reg[1:0] == 2'd0) && ((ymod100_reg != 7'd0) || (ymod400_reg == 9'd0));
    assign ylen = leap ? esc_pkg::DAYS_LEAP : esc_pkg::DAYS_COMMON;
    assign mlen = esc_pkg::month_len(month_reg, leap);

    assign status.year_stop  = rem_reg < {7'd0, ylen};
    assign status.month_stop = (rem_reg < {11'd0, mlen}) || (month_reg == esc_pkg::LAST_MONTH);

    // Next-state selection per command
    always_comb
    begin
        work_next    = work_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        wday_next    = wday_reg;
        rem_next     = rem_reg;
        year_next    = year_reg;
        ymod100_next = ymod100_reg;
        ymod400_next = ymod400_reg;
        month_next   = month_reg;
        case (cmd.op)
            esc_pkg::OP_LOAD:
            begin
                work_next    = epoch_seconds;
                year_next    = esc_pkg::EPOCH_YEAR;
                ymod100_next = esc_pkg::EPOCH_MOD100;
                ymod400_next = esc_pkg::EPOCH_MOD400;
                month_next   = 4'd0;
            end
            esc_pkg::OP_SPL60S:
            begin
                sec_next  = r60[5:0];
                work_next = {5'd0, q60};
            end
            esc_pkg::OP_SPL60M:
            begin
                min_next  = r60[5:0];
                work_next = {5'd0, q60};
            end
            esc_pkg::OP_SPL24:
            begin
                hour_next = r24[4:0];
                rem_next  = q24;
                // weekday offset: day zero was a Thursday
                work_next = {16'd0, q24} + 32'd4;
            end
            esc_pkg::OP_SPL7:
            begin
                wday_next = r7[2:0] + 3'd1;
            end
            esc_pkg::OP_YEAR:
            begin
                if (!status.year_stop)
                begin
                    rem_next     = rem_reg - {7'd0, ylen};
                    year_next    = year_reg + 12'd1;
                    ymod100_next = (ymod100_reg == 7'd99) ? 7'd0 : ymod100_reg + 7'd1;
                    ymod400_next = (ymod400_reg == 9'd399) ? 9'd0 : ymod400_reg + 9'd1;
                end
            end
            esc_pkg::OP_MONTH:
            begin
                if (rem_reg >= {11'd0, mlen})
                begin
                    rem_next = rem_reg - {11'd0, mlen};
                    if (month_reg != esc_pkg::LAST_MONTH)
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        sec_reg     <= sec_next;
        min_reg     <= min_next;
        hour_reg    <= hour_next;
        wday_reg    <= wday_next;
        rem_reg     <= rem_next;
        year_reg    <= year_next;
        ymod100_reg <= ymod100_next;
        ymod400_reg <= ymod400_next;
        month_reg   <= month_next;
        if ((cmd.op == esc_pkg::OP_MUL60S) || (cmd.op == esc_pkg::OP_MUL60M) ||
            (cmd.op == esc_pkg::OP_MUL24) || (cmd.op == esc_pkg::OP_MUL7))
        begin
            prod_reg <= prod_next;
        end
        if (cmd.op == esc_pkg::OP_PUBLISH)
        begin
            out_sec_reg   <= sec_reg;
            out_min_reg   <= min_reg;
            out_hour_reg  <= hour_reg;
            out_wday_reg  <= wday_reg;
            out_year_reg  <= year_reg;
            out_month_reg <= month_reg + 4'd1;
            out_day_reg   <= rem_reg[4:0] + 5'd1;
        end
    end

    assign second_of_minute = out_sec_reg;
    assign minute_of_hour   = out_min_reg;
    assign hour_of_day      = out_hour_reg;
    assign day_of_week      = out_wday_reg;
    assign calendar_year    = out_year_reg;
    assign month_number     = out_month_reg;
    assign day_of_month     = out_day_reg;

endmodule

`default_nettype wire

[hw/rtl/esc_ctrl.sv]
// Controller: sequences the divide steps and the year and month walks.
// Depends on esc_pkg; drives esc_datapath through cmd_t.
`default_nettype none

module esc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire esc_pkg::status_t  status,
    output esc_pkg::cmd_t          cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL60S = 4'd1;
    localparam logic [3:0] ST_SPL60S = 4'd2;
    localparam logic [3:0] ST_MUL60M = 4'd3;
    localparam logic [3:0] ST_SPL60M = 4'd4;
    localparam logic [3:0] ST_MUL24  = 4'd5;
    localparam logic [3:0] ST_SPL24  = 4'd6;
    localparam logic [3:0] ST_MUL7   = 4'd7;
    localparam logic [3:0] ST_SPL7   = 4'd8;
    localparam logic [3:0] ST_YEAR   = 4'd9;
    localparam logic [3:0] ST_MONTH  = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = esc_pkg::OP_NONE;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = esc_pkg::OP_LOAD;
                    state_next = ST_MUL60S;
                end
            end
            ST_MUL60S:
            begin
                cmd.op     = esc_pkg::OP_MUL60S;
                state_next = ST_SPL60S;
            end
            ST_SPL60S:
            begin
                cmd.op     = esc_pkg::OP_SPL60S;
                state_next = ST_MUL60M;
            end
            ST_MUL60M:
            begin
                cmd.op     = esc_pkg::OP_MUL60M;
                state_next = ST_SPL60M;
            end
            ST_SPL60M:
            begin
                cmd.op     = esc_pkg::OP_SPL60M;
                state_next = ST_MUL24;
            end
            ST_MUL24:
            begin
                cmd.op     = esc_pkg::OP_MUL24;
                state_next = ST_SPL24;
            end
            ST_SPL24:
            begin
                cmd.op     = esc_pkg::OP_SPL24;
                state_next = ST_MUL7;
            end
            ST_MUL7:
            begin
                cmd.op     = esc_pkg::OP_MUL7;
                state_next = ST_SPL7;
            end
            ST_SPL7:
            begin
                cmd.op     = esc_pkg::OP_SPL7;
                state_next = ST_YEAR;
            end
            ST_YEAR:
            begin
                cmd.op = esc_pkg::OP_YEAR;
                if (status.year_stop)
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                cmd.op = esc_pkg::OP_MONTH;
                if (status.month_stop)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hand over once the output slot is free
                if (slot_free)
                begin
                    cmd.op         = esc_pkg::OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // accepted beat starts the divide sequence
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MUL60S))
        else $error("accepted beat did not start conversion");

    // result registers only overwritten when the slot is free
    a_publish: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == esc_pkg::OP_PUBLISH) |-> slot_free)
        else $error("result overwritten while still pending");

    // year walk stop hands over to the month walk
    a_year_month: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YEAR && status.year_stop) |=> (state_reg == ST_MONTH))
        else $error("year walk did not hand over to month walk");

    // publishing raises the output valid
    a_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == esc_pkg::OP_PUBLISH) |=> out_valid_reg)
        else $error("publish did not raise out_valid");
`endif

endmodule

`default_nettype wire

[hw/rtl/epoch_seconds_to_calendar_core.sv]
// Epoch seconds to calendar converter, top level.
// Input channel: in_valid/in_ready, one beat carries epoch_seconds (unsigned 32-bit).
// Output channel: out_valid/out_ready, one beat carries second, minute, hour,
// weekday (1 = Sunday), full year, month (1..12) and day of month.
// One input beat gives exactly one output beat, in order.
// From acceptance to out_valid, the controller first runs three reciprocal
// divides and the weekday modulo, each as a multiply and a split step, on one
// shared 32x32 multiplier; then the year walk steps once per year past 1970,
// the month walk once per month, and a last step loads the result register.
// The controller works on a single item at a time: the next beat is accepted
// only once the last one has been handed to the output register.
// The result sits in an output register, so the next beat is accepted while a
// finished result still waits. If the receiver stalls, the following result is
// held inside until the register is taken; no result is dropped.
// Reset (rst_n, asynchronous, active low) empties the output and returns the
// controller to idle; the block keeps no other state between items.
// Depends on esc_pkg, esc_ctrl and esc_datapath.
`default_nettype none

module epoch_seconds_to_calendar_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] epoch_seconds,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       second_of_minute,
    output logic [5:0]       minute_of_hour,
    output logic [4:0]       hour_of_day,
    output logic [2:0]       day_of_week,
    output logic [11:0]      calendar_year,
    output logic [3:0]       month_number,
    output logic [4:0]       day_of_month
);

    esc_pkg::cmd_t    cmd;
    esc_pkg::status_t status;

    esc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    esc_datapath u_datapath (
        .clk              (clk),
        .cmd              (cmd),
        .epoch_seconds    (epoch_seconds),
        .status           (status),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_week      (day_of_week),
        .calendar_year    (calendar_year),
        .month_number     (month_number),
        .day_of_month     (day_of_month)
    );

endmodule

`default_nettype wire

[sim/esc_calendar_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for epoch_seconds_to_calendar_core: predicts the calendar fields
// of every accepted input beat and checks output beats in order.
// Needs only the clock, reset and the ports of the core; no package import.

module esc_calendar_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] epoch_seconds,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [5:0]  second_of_minute,
    input  logic [5:0]  minute_of_hour,
    input  logic [4:0]  hour_of_day,
    input  logic [2:0]  day_of_week,
    input  logic [11:0] calendar_year,
    input  logic [3:0]  month_number,
    input  logic [4:0]  day_of_month,
    output int          dates_pending,
    output int          error_count
);

    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [2:0]  wday;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
    } calendar_t;

    calendar_t expected_dates [$];
    calendar_t seen_date;
    calendar_t want_date;
    int        pending_count = 0;
    int        mismatches = 0;

    assign dates_pending = pending_count;
    assign error_count   = mismatches;

    // Gregorian rule on the full year: century years only every 400
    function automatic bit gregorian_leap(input int unsigned year);
        return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned month, input bit leap);
        int unsigned len;
        case (month)
            1:       len = leap ? 29 : 28;
            3, 5, 8, 10: len = 30;
            default: len = 31;
        endcase
        return len;
    endfunction

    // Seconds since 1970-01-01 to broken-down calendar date
    function automatic calendar_t decode_epoch(input logic [31:0] secs);
        calendar_t   cal;
        int unsigned rest;
        int unsigned day_count;
        int unsigned year;
        int unsigned month;
        int unsigned year_len;
        rest      = secs;
        cal.sec   = 6'(rest % 60);
        rest      = rest / 60;
        cal.min   = 6'(rest % 60);
        rest      = rest / 60;
        cal.hour  = 5'(rest % 24);
        day_count = rest / 24;
        // 1970-01-01 was a Thursday, Sunday counts as 1
        cal.wday  = 3'((day_count + 4) % 7 + 1);

        // year walk
        year     = 1970;
        year_len = gregorian_leap(year) ? 366 : 365;
        while (day_count >= year_len) begin
            day_count = day_count - year_len;
            year      = year + 1;
            year_len  = gregorian_leap(year) ? 366 : 365;
        end

        // month walk, December always stops it
        month = 0;
        while (month < 11 && day_count >= days_in_month(month, gregorian_leap(year))) begin
            day_count = day_count - days_in_month(month, gregorian_leap(year));
            month     = month + 1;
        end

        cal.year  = 12'(year);
        cal.month = 4'(month + 1);
        cal.mday  = 5'(day_count + 1);
        return cal;
    endfunction

    task automatic compare_field(input string field, input logic [11:0] want,
                                 input logic [11:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Output beat first: a beat's own result never leaves at its accepting edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                seen_date = {second_of_minute, minute_of_hour, hour_of_day, day_of_week,
                             calendar_year, month_number, day_of_month};
                if (expected_dates.size() == 0) begin
                    $error("output beat with no input beat outstanding: %0d-%0d-%0d",
                           calendar_year, month_number, day_of_month);
                    mismatches++;
                end
                else begin
                    want_date = expected_dates.pop_front();
                    compare_field("second_of_minute", 12'(want_date.sec), 12'(seen_date.sec));
                    compare_field("minute_of_hour", 12'(want_date.min), 12'(seen_date.min));
                    compare_field("hour_of_day", 12'(want_date.hour), 12'(seen_date.hour));
                    compare_field("day_of_week", 12'(want_date.wday), 12'(seen_date.wday));
                    compare_field("calendar_year", want_date.year, seen_date.year);
                    compare_field("month_number", 12'(want_date.month),
                                  12'(seen_date.month));
                    compare_field("day_of_month", 12'(want_date.mday), 12'(seen_date.mday));
                end
            end
            if (in_valid && in_ready)
                expected_dates.push_back(decode_epoch(epoch_seconds));
            pending_count <= expected_dates.size();
        end
    end

endmodule

[sim/tb_epoch_seconds_to_calendar_core.sv]
`timescale 1ns / 100ps
// Testbench top for epoch_seconds_to_calendar_core: drives corner and random
// epoch counts under varying back-pressure and reports the verdict.
// Depends on the core RTL and on esc_calendar_checker.

module tb_epoch_seconds_to_calendar_core;

    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int RANDOM_PER_PHASE = 567;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] epoch_seconds = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [2:0]  day_of_week;
    logic [11:0] calendar_year;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;

    int dates_pending;
    int error_count;
    int send_idle_pct = 28;
    int recv_idle_pct = 81;
    int quiet_cycles = 0;

    // Corner dates: field wraps, leap days, century years, top of range
    logic [31:0] corner_seconds [$] = '{
        32'd0,            // epoch start, Thursday
        32'd59, 32'd60,   // minute wrap
        32'd3599, 32'd3600,
        32'd86399, 32'd86400,
        32'd31535999,     // 1970-12-31 23:59:59
        32'd31536000,     // 1971-01-01
        32'd68169600,     // 1972-02-29, first leap day
        32'd94694399,     // end of 1972
        32'd951782400,    // 2000-02-29, century leap year
        32'd951868800,    // 2000-03-01
        32'd978220800,    // 2000-12-31
        32'd2147483647,   // top of signed range
        32'd2147483648,
        32'd4107456000,   // 2100-02-28, century common year
        32'd4107542400,   // 2100-03-01
        32'h5555_5555, 32'hAAAA_AAAA,
        32'hFFFF_FFFE,
        32'hFFFF_FFFF     // 2106-02-07 06:28:15
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    epoch_seconds_to_calendar_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .epoch_seconds    (epoch_seconds),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_week      (day_of_week),
        .calendar_year    (calendar_year),
        .month_number     (month_number),
        .day_of_month     (day_of_month)
    );

    esc_calendar_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .epoch_seconds    (epoch_seconds),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_week      (day_of_week),
        .calendar_year    (calendar_year),
        .month_number     (month_number),
        .day_of_month     (day_of_month),
        .dates_pending    (dates_pending),
        .error_count      (error_count)
    );

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: cycles in a row with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_epoch_seconds_to_calendar_core: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Half full-range counts, the rest clustered on small values, the top
    // of the range, the 2000 and 2100 February ends and day boundaries
    function automatic logic [31:0] random_seconds();
        logic [31:0] value;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: value = $urandom();
            5:       value = $urandom_range(0, 400000000);
            6:       value = 32'hFFFF_FFFF - $urandom_range(0, 40000000);
            7:       value = 32'd4107369600 + $urandom_range(0, 259200);
            8:       value = 32'd951696000 + $urandom_range(0, 345600);
            default: value = $urandom_range(0, 49709) * 32'd86400
                             + ($urandom_range(0, 1) ? 32'd86399 : 32'd0);
        endcase
        return value;
    endfunction

    // Send one beat, with a random gap before it; returns at the accepting edge
    task automatic push_seconds(input logic [31:0] value);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        epoch_seconds <= value;
        do @(posedge clk); while (!in_ready);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_seconds[i])
            push_seconds(corner_seconds[i]);

        // sender light / receiver heavy, then swapped, then no idling
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 28 : 0;
            repeat (RANDOM_PER_PHASE)
                push_seconds(random_seconds());
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (dates_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_epoch_seconds_to_calendar_core: clean");
        else
            $display("tb_epoch_seconds_to_calendar_core: errors");
        $finish;
    end

endmodule
